[rtl/date_difference_in_days_assert.svh]
// ----------------------------------------------------------------------------
// Date difference assertion macros
// Shared property templates for the date difference block: an implication
// in the same cycle and an implication in the cycle after, both reset-gated.
// ----------------------------------------------------------------------------
`ifndef DATE_DIFFERENCE_IN_DAYS_ASSERT_SVH
`define DATE_DIFFERENCE_IN_DAYS_ASSERT_SVH

// Check that cond holds in the same cycle as trig.
`define DDAYS_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("same-cycle check failed");

// Check that cond holds in the cycle after trig.
`define DDAYS_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("next-cycle check failed");

`endif

[rtl/ddays_pkg.sv]
// ----------------------------------------------------------------------------
// Date difference package
// Status codes, stage advance struct and calendar tables shared by the
// date converter and the top level.
// ----------------------------------------------------------------------------
package ddays_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_EARLIER = 2'd1,
        ST_BAD_LATER   = 2'd2,
        ST_ORDER       = 2'd3
    } status_t;

    // Per-stage load enables of the converter pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } ddays_adv_t;

    localparam int unsigned NUM_W   = 22;
    localparam int unsigned COUNT_W = 22;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned VAL_W   = 7;

    // Length of a month, 1..12, given the leap flag of its year
    function automatic logic [4:0] month_len(input logic [VAL_W-1:0] m, input logic leap);
        logic [4:0] len;
        begin
            case (m)
                7'd2:    len = leap ? 5'd29 : 5'd28;
                7'd4,
                7'd6,
                7'd9,
                7'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // Days before the first of a month, counted from March
    function automatic logic [DOY_W-1:0] days_before(input logic [3:0] mp);
        logic [DOY_W-1:0] days;
        begin
            case (mp)
                4'd0:    days = 9'd0;
                4'd1:    days = 9'd31;
                4'd2:    days = 9'd61;
                4'd3:    days = 9'd92;
                4'd4:    days = 9'd122;
                4'd5:    days = 9'd153;
                4'd6:    days = 9'd184;
                4'd7:    days = 9'd214;
                4'd8:    days = 9'd245;
                4'd9:    days = 9'd275;
                4'd10:   days = 9'd306;
                4'd11:   days = 9'd337;
                default: days = 9'd0;
            endcase
            return days;
        end
    endfunction

endpackage

[rtl/ddays_conv.sv]
// ----------------------------------------------------------------------------
// Date to day number converter
// Four-stage pipeline: parse eight ASCII digits, validate and split the
// year, form the constant products, and add them into a day number.
// ----------------------------------------------------------------------------
module ddays_conv
    import ddays_pkg::*;
(
    input  logic              clk,
    input  ddays_adv_t        adv,
    input  logic [63:0]       text,
    output logic              date_ok,
    output logic [NUM_W-1:0]  day_num
);

    // Stage 1: parse digits
    logic             dig_ok_reg, dig_ok_next;
    logic [VAL_W-1:0] cc_reg, cc_next;
    logic [VAL_W-1:0] yl_reg, yl_next;
    logic [VAL_W-1:0] mon_reg, mon_next;
    logic [VAL_W-1:0] day_reg, day_next;

    always_comb
    begin
        logic [7:0]       ch;
        logic [3:0]       dig [8];
        logic             all_ok;
        all_ok = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            ch     = text[63-8*i -: 8];
            dig[i] = ch[3:0];
            if (ch < 8'h30 || ch > 8'h39)
            begin
                all_ok = 1'b0;
            end
        end
        dig_ok_next = all_ok;
        cc_next  = VAL_W'({3'b000, dig[0]}) * VAL_W'(10) + VAL_W'({3'b000, dig[1]});
        yl_next  = VAL_W'({3'b000, dig[2]}) * VAL_W'(10) + VAL_W'({3'b000, dig[3]});
        mon_next = VAL_W'({3'b000, dig[4]}) * VAL_W'(10) + VAL_W'({3'b000, dig[5]});
        day_next = VAL_W'({3'b000, dig[6]}) * VAL_W'(10) + VAL_W'({3'b000, dig[7]});
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            dig_ok_reg <= dig_ok_next;
            cc_reg     <= cc_next;
            yl_reg     <= yl_next;
            mon_reg    <= mon_next;
            day_reg    <= day_next;
        end
    end

    // Stage 2: validate, shift the year to start in March, day of year
    logic             ok2_reg, ok2_next;
    logic [VAL_W-1:0] cen_reg, cen_next;
    logic [VAL_W-1:0] low_reg, low_next;
    logic [DOY_W-1:0] doy_reg, doy_next;

    always_comb
    begin
        logic       leap;
        logic       early;
        logic [3:0] mp;
        leap  = (yl_reg[1:0] == 2'b00) && ((yl_reg != '0) || (cc_reg[1:0] == 2'b00));
        early = (mon_reg <= VAL_W'(2));
        ok2_next = dig_ok_reg
                && (mon_reg >= VAL_W'(1)) && (mon_reg <= VAL_W'(12))
                && (day_reg >= VAL_W'(1))
                && (day_reg <= VAL_W'(month_len(mon_reg, leap)));
        mp = early ? 4'(mon_reg + VAL_W'(9)) : 4'(mon_reg - VAL_W'(3));
        doy_next = days_before(mp) + DOY_W'(day_reg) - DOY_W'(1);
        // Year plus 400, less one for January and February
        if (!early)
        begin
            cen_next = cc_reg + VAL_W'(4);
            low_next = yl_reg;
        end
        else if (yl_reg != '0)
        begin
            cen_next = cc_reg + VAL_W'(4);
            low_next = yl_reg - VAL_W'(1);
        end
        else
        begin
            cen_next = cc_reg + VAL_W'(3);
            low_next = VAL_W'(99);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            ok2_reg <= ok2_next;
            cen_reg <= cen_next;
            low_reg <= low_next;
            doy_reg <= doy_next;
        end
    end

    // Stage 3: constant products of centuries and years
    logic             ok3_reg;
    logic [NUM_W-1:0] pc_reg, pc_next;
    logic [15:0]      pl_reg, pl_next;

    always_comb
    begin
        pc_next = NUM_W'(cen_reg) * NUM_W'(36524);
        pl_next = 16'(low_reg) * 16'd365 + 16'(low_reg >> 2) + 16'(cen_reg >> 2)
                + 16'(doy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            ok3_reg <= ok2_reg;
            pc_reg  <= pc_next;
            pl_reg  <= pl_next;
        end
    end

    // Stage 4: sum into the day number
    logic             ok4_reg;
    logic [NUM_W-1:0] num_reg, num_next;

    assign num_next = pc_reg + NUM_W'(pl_reg);

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            ok4_reg <= ok3_reg;
            num_reg <= num_next;
        end
    end

    assign date_ok = ok4_reg;
    assign day_num = num_reg;

endmodule

[rtl/date_difference_in_days.sv]
// ----------------------------------------------------------------------------
// Days between two Gregorian dates
// Takes two yyyymmdd ASCII dates a word and returns a status and the day
// count from the earlier to the later date.
// ----------------------------------------------------------------------------
// A word is taken in every cycle while the pipeline moves and passes through
// four converter stages (parse, validate, constant multiply, add) and one
// compare-and-subtract stage that is also the output register. The 16-by-7-bit
// constant multiply sets the stage depth. A stall on the result side holds the
// full stages only; bubbles close up, so words keep entering until every stage
// is occupied. Status 1 wins over 2 when both dates are bad; day_count is zero
// unless the status is ok.
module date_difference_in_days
    import ddays_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [63:0]        earlier_date_text,
    input  logic [63:0]        later_date_text,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [1:0]         status,
    output logic [COUNT_W-1:0] day_count
);

`include "date_difference_in_days_assert.svh"

    // Stage valid bits, stage 5 is the output register
    logic [5:1] vld_reg, vld_next;
    logic [5:1] rdy;
    ddays_adv_t adv;

    // Advance a stage when it is empty or its successor advances
    always_comb
    begin
        rdy[5] = !vld_reg[5] || !result_stall;
        for (int k = 4; k >= 1; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        adv = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4]};
        vld_next[1] = rdy[1] ? item_valid : vld_reg[1];
        for (int k = 2; k <= 5; k++)
        begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign item_stall = !rdy[1];

    // Convert both dates in parallel
    logic             ok_a, ok_b;
    logic [NUM_W-1:0] num_a, num_b;

    ddays_conv u_conv_earlier (
        .clk     (clk),
        .adv     (adv),
        .text    (earlier_date_text),
        .date_ok (ok_a),
        .day_num (num_a)
    );

    ddays_conv u_conv_later (
        .clk     (clk),
        .adv     (adv),
        .text    (later_date_text),
        .date_ok (ok_b),
        .day_num (num_b)
    );

    // Stage 5: classify and subtract
    status_t            status_reg, status_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        count_next = '0;
        if (!ok_a)
        begin
            status_next = ST_BAD_EARLIER;
        end
        else if (!ok_b)
        begin
            status_next = ST_BAD_LATER;
        end
        else if (num_b < num_a)
        begin
            status_next = ST_ORDER;
        end
        else
        begin
            status_next = ST_OK;
            count_next  = COUNT_W'(num_b - num_a);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            status_reg <= status_next;
            count_reg  <= count_next;
        end
    end

    assign result_valid = vld_reg[5];
    assign status       = status_reg;
    assign day_count    = count_reg;

    // Checks
    `DDAYS_ASSERT_SAME(a_count_zero_on_error, clk, rst_n,
        result_valid && (status_reg != ST_OK), day_count == '0)
    `DDAYS_ASSERT_SAME(a_count_in_range, clk, rst_n,
        result_valid, day_count <= COUNT_W'(3652425))
    `DDAYS_ASSERT_SAME(a_stall_only_when_full, clk, rst_n,
        item_stall, vld_reg[1] && vld_reg[2] && vld_reg[3] && vld_reg[4] && vld_reg[5])
    `DDAYS_ASSERT_NEXT(a_last_stage_delivers, clk, rst_n,
        vld_reg[4] && rdy[5], result_valid)

endmodule
